@@ hdl/bootstring_identifier_decoder_top_macros.svh @@
// Assertion macros for the identifier decoder.
`ifndef BOOTSTRING_IDENTIFIER_DECODER_TOP_MACROS_SVH
`define BOOTSTRING_IDENTIFIER_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BID_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define BID_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define BID_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define BID_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

@@ hdl/bid_pkg.sv @@
package bid_pkg;

    localparam int MAX_CHARS_DEF = 64;
    localparam int CODE_W        = 21;
    localparam int RES_W         = 32;
    localparam int NUM_W         = 64;
    localparam int DIG_W         = 6;

    localparam logic [DIG_W-1:0] DIGIT_BASE   = 6'd62;
    localparam logic [DIG_W-1:0] DIGIT_THRESH = 6'd31;
    localparam logic [CODE_W-1:0] SPLIT_MARK  = 21'h5F;

    localparam logic [1:0] ST_DECODED = 2'd0;
    localparam logic [1:0] ST_NO_PFX  = 2'd1;
    localparam logic [1:0] ST_DEC_ERR = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [3:0] {
        S_COLLECT,
        S_DECIDE,
        S_LIT_RD,
        S_LIT_WR,
        S_DIG_RD,
        S_DIG_MUL,
        S_DIG_ADD,
        S_DIV_WAIT,
        S_SHF_RD,
        S_SHF_WR,
        S_INS,
        S_FIN,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_HOLD
    } t_state;

    // Expected code point of the prefix at positions zero to three.
    function automatic logic [CODE_W-1:0] pfx_char(input logic [1:0] idx);
        logic [CODE_W-1:0] c;
        unique case (idx)
            2'd0: c = 21'h74;
            2'd1: c = 21'h6E;
            default: c = SPLIT_MARK;
        endcase
        return c;
    endfunction

    // Base-62 digit value; 64 marks a code point that is no digit.
    function automatic logic [DIG_W:0] digit_of(input logic [CODE_W-1:0] c);
        logic [DIG_W:0] d;
        if (c >= 21'h30 && c <= 21'h39) begin
            d = 7'(c - 21'h30);
        end else if (c >= 21'h41 && c <= 21'h5A) begin
            d = 7'(c - 21'h41 + 21'd10);
        end else if (c >= 21'h61 && c <= 21'h7A) begin
            d = 7'(c - 21'h61 + 21'd36);
        end else begin
            d = 7'd64;
        end
        return d;
    endfunction

endpackage

@@ hdl/bid_ram.sv @@
module bid_ram
    import bid_pkg::*;
#(
    parameter int WIDTH = RES_W,
    parameter int DEPTH = MAX_CHARS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bid_div.sv @@
module bid_div
    import bid_pkg::*;
#(
    parameter int DVS_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [RES_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);

    logic                     r_busy;
    logic                     r_done;
    logic [$clog2(NUM_W)-1:0] r_cnt;
    logic [NUM_W-1:0]         r_quo;
    logic [DVS_W-1:0]         r_rem;
    logic [DVS_W-1:0]         r_dvs;
    logic [DVS_W:0]           w_trial;
    logic                     w_ge;
    logic [DVS_W:0]           w_diff;

    // Restoring division, one quotient bit per cycle, MSB first.
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_ge ? (w_trial - {1'b0, r_dvs}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[NUM_W-2:0], w_ge};
                r_rem <= w_diff[DVS_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo[RES_W-1:0];
    assign o_remainder = r_rem;

endmodule

@@ hdl/bootstring_identifier_decoder_top.sv @@
// Input: one code point accepted per cycle while collecting; no result until the last one.
// Decode burst: each literal is read and written, each digit read, scaled and added, and each
// number goes through the bit-serial 64-bit divider, a shift of result entries and an insert.
// Output: each item is read from the buffer memory and held until out_ready is high.
// Reset is synchronous and active low; it clears counters and flags, not the memories.
`include "bootstring_identifier_decoder_top_macros.svh"
module bootstring_identifier_decoder_top
    import bid_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CODE_W-1:0] i_char_code,
    input  logic              i_bad_utf8,
    input  logic              i_last_char,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [RES_W-1:0]  o_out_code,
    output logic [1:0]        o_status,
    output logic              o_last_out
);

    localparam int AW = $clog2(MAX_CHARS);
    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_CHARS);
    localparam logic [CW-1:0] FOUR = CW'(4);
    localparam logic [CW-1:0] ONE  = CW'(1);

    t_state r_state, n_state;

    logic [CW-1:0]    r_in_count, r_res_count, r_split, r_idx, r_j, r_k, r_pos;
    logic             r_err, r_too_long, r_pfx_ok;
    logic [RES_W-1:0] r_rc;
    logic [NUM_W-1:0] r_pn, r_w;
    logic [DIG_W-1:0] r_dig;
    logic [NUM_W+DIG_W-1:0] r_prod;
    logic             r_emit_src;
    logic [1:0]       r_emit_status;
    logic             r_out_valid, r_out_last;
    logic [RES_W-1:0] r_out_code;
    logic [1:0]       r_out_status;

    logic              w_acc;
    logic              w_pfx_good;
    logic [DIG_W:0]    w_digit;
    logic [NUM_W+DIG_W:0] w_sum;
    logic              w_ovf, w_small, w_full, w_wovf, w_add_err;
    logic [NUM_W+4:0]  w_w31;
    logic [CW-1:0]     w_dig_start, w_emit_n;

    logic              in_we, in_re, res_we, res_re, div_start;
    logic [AW-1:0]     in_waddr, in_raddr, res_waddr, res_raddr;
    logic [RES_W-1:0]  res_wdata;
    logic [CODE_W-1:0] in_rdata;
    logic [RES_W-1:0]  res_rdata;
    logic              div_done;
    logic [RES_W-1:0]  div_quo;
    logic [CW-1:0]     div_rem;

    bid_ram #(.WIDTH(CODE_W), .DEPTH(MAX_CHARS)) u_in_ram (
        .i_clk(i_clk), .i_we(in_we), .i_waddr(in_waddr), .i_wdata(i_char_code),
        .i_re(in_re), .i_raddr(in_raddr), .o_rdata(in_rdata)
    );

    bid_ram #(.WIDTH(RES_W), .DEPTH(MAX_CHARS)) u_res_ram (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(res_waddr), .i_wdata(res_wdata),
        .i_re(res_re), .i_raddr(res_raddr), .o_rdata(res_rdata)
    );

    bid_div #(.DVS_W(CW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(w_sum[NUM_W-1:0]), .i_divisor(CW'(r_res_count + ONE)),
        .o_done(div_done), .o_quotient(div_quo), .o_remainder(div_rem)
    );

    always_comb begin
        w_acc       = i_in_valid && o_in_ready;
        w_pfx_good  = (r_in_count >= FOUR) && r_pfx_ok;
        w_digit     = digit_of(in_rdata);
        w_sum       = {1'b0, r_prod} + {{(DIG_W+1){1'b0}}, r_pn};
        w_ovf       = |w_sum[NUM_W+DIG_W:NUM_W];
        w_small     = (r_dig < DIGIT_THRESH);
        w_full      = (r_res_count >= MAXC);
        // Weight times 31 as a shift and subtract.
        w_w31       = ({5'b0, r_w} << 5) - {5'b0, r_w};
        w_wovf      = |w_w31[NUM_W+4:NUM_W];
        w_add_err   = w_ovf || (w_small ? w_full : w_wovf);
        w_dig_start = CW'(r_split + CW'(5));
        w_emit_n    = r_emit_src ? r_res_count : r_in_count;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: if (w_acc && i_last_char) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_too_long || !w_pfx_good || r_err) n_state = S_EMIT_RD;
                else if (r_split != '0) n_state = S_LIT_RD;
                else if (FOUR < r_in_count) n_state = S_DIG_RD;
                else n_state = S_FIN;
            end
            S_LIT_RD: n_state = S_LIT_WR;
            S_LIT_WR: begin
                if (CW'(r_idx + ONE) != r_split) n_state = S_LIT_RD;
                else if (w_dig_start < r_in_count) n_state = S_DIG_RD;
                else n_state = S_FIN;
            end
            S_DIG_RD: n_state = S_DIG_MUL;
            S_DIG_MUL: n_state = ({1'b0, DIGIT_BASE} <= w_digit) ? S_EMIT_RD : S_DIG_ADD;
            S_DIG_ADD: begin
                if (w_add_err) n_state = S_EMIT_RD;
                else if (w_small) n_state = S_DIV_WAIT;
                else if (CW'(r_idx + ONE) < r_in_count) n_state = S_DIG_RD;
                else n_state = S_FIN;
            end
            S_DIV_WAIT: if (div_done) n_state = S_SHF_RD;
            S_SHF_RD: n_state = (r_j == r_pos) ? S_INS : S_SHF_WR;
            S_SHF_WR: n_state = S_SHF_RD;
            S_INS: n_state = (CW'(r_idx + ONE) < r_in_count) ? S_DIG_RD : S_FIN;
            S_FIN: begin
                if (r_w != NUM_W'(1)) n_state = S_EMIT_RD;
                else if (r_res_count == '0) n_state = S_COLLECT;
                else n_state = S_EMIT_RD;
            end
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: n_state = S_EMIT_HOLD;
            S_EMIT_HOLD: begin
                if (i_out_ready) n_state = r_out_last ? S_COLLECT : S_EMIT_RD;
            end
            default: n_state = S_COLLECT;
        endcase
    end

    // Memory and divider controls.
    always_comb begin
        in_we     = 1'b0;
        in_waddr  = r_in_count[AW-1:0];
        in_re     = 1'b0;
        in_raddr  = r_k[AW-1:0];
        res_we    = 1'b0;
        res_waddr = r_idx[AW-1:0];
        res_wdata = {{(RES_W-CODE_W){1'b0}}, in_rdata};
        res_re    = 1'b0;
        res_raddr = r_k[AW-1:0];
        div_start = 1'b0;
        o_in_ready = (r_state == S_COLLECT);
        unique case (r_state)
            S_COLLECT: in_we = w_acc && (r_in_count < MAXC);
            S_LIT_RD: begin
                in_re    = 1'b1;
                in_raddr = AW'(r_idx + FOUR);
            end
            S_LIT_WR: res_we = 1'b1;
            S_DIG_RD: begin
                in_re    = 1'b1;
                in_raddr = r_idx[AW-1:0];
            end
            S_DIG_ADD: div_start = !w_add_err && w_small;
            S_SHF_RD: begin
                res_re    = (r_j != r_pos);
                res_raddr = AW'(r_j - ONE);
            end
            S_SHF_WR: begin
                res_we    = 1'b1;
                res_waddr = r_j[AW-1:0];
                res_wdata = res_rdata;
            end
            S_INS: begin
                res_we    = 1'b1;
                res_waddr = r_pos[AW-1:0];
                res_wdata = r_rc;
            end
            S_EMIT_RD: begin
                in_re  = 1'b1;
                res_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_in_count  <= '0;
            r_res_count <= '0;
            r_split     <= '0;
            r_err       <= 1'b0;
            r_too_long  <= 1'b0;
            r_pfx_ok    <= 1'b1;
            r_rc        <= '0;
            r_pn        <= '0;
            r_w         <= NUM_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_COLLECT: begin
                    if (w_acc) begin
                        if (r_in_count < MAXC) begin
                            r_in_count <= CW'(r_in_count + ONE);
                            if (i_bad_utf8) r_err <= 1'b1;
                            if (r_in_count < FOUR) begin
                                if (i_char_code != pfx_char(r_in_count[1:0])) begin
                                    r_pfx_ok <= 1'b0;
                                end
                            end else if (i_char_code == SPLIT_MARK) begin
                                r_split <= CW'(r_in_count - FOUR);
                            end
                        end else begin
                            r_too_long <= 1'b1;
                        end
                    end
                end
                S_DECIDE: begin
                    r_k        <= '0;
                    r_emit_src <= 1'b0;
                    r_idx      <= (r_split != '0) ? '0 : FOUR;
                    if (r_too_long) r_emit_status <= ST_TOO_LONG;
                    else if (!w_pfx_good) r_emit_status <= ST_NO_PFX;
                    else r_emit_status <= ST_DEC_ERR;
                end
                S_LIT_WR: begin
                    r_res_count <= CW'(r_idx + ONE);
                    r_idx <= (CW'(r_idx + ONE) == r_split) ? w_dig_start : CW'(r_idx + ONE);
                end
                S_DIG_MUL: begin
                    r_dig  <= w_digit[DIG_W-1:0];
                    r_prod <= {{DIG_W{1'b0}}, r_w} * {{NUM_W{1'b0}}, w_digit[DIG_W-1:0]};
                    r_emit_status <= ST_DEC_ERR;
                end
                S_DIG_ADD: begin
                    r_pn <= w_sum[NUM_W-1:0];
                    r_j  <= r_res_count;
                    if (!w_small) begin
                        r_w   <= w_w31[NUM_W-1:0];
                        r_idx <= CW'(r_idx + ONE);
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_rc  <= r_rc + div_quo;
                        r_pos <= div_rem;
                    end
                end
                S_SHF_WR: r_j <= CW'(r_j - ONE);
                S_INS: begin
                    r_res_count <= CW'(r_res_count + ONE);
                    r_pn  <= '0;
                    r_w   <= NUM_W'(1);
                    r_idx <= CW'(r_idx + ONE);
                end
                S_FIN: begin
                    r_emit_status <= (r_w != NUM_W'(1)) ? ST_DEC_ERR : ST_DECODED;
                    r_emit_src    <= (r_w == NUM_W'(1));
                    if (r_w == NUM_W'(1) && r_res_count == '0) begin
                        r_in_count  <= '0;
                        r_res_count <= '0;
                        r_split     <= '0;
                        r_err       <= 1'b0;
                        r_too_long  <= 1'b0;
                        r_pfx_ok    <= 1'b1;
                        r_rc        <= '0;
                        r_pn        <= '0;
                        r_w         <= NUM_W'(1);
                    end
                end
                S_EMIT_LD: begin
                    r_out_valid  <= 1'b1;
                    r_out_code   <= r_emit_src ? res_rdata
                                               : {{(RES_W-CODE_W){1'b0}}, in_rdata};
                    r_out_status <= r_emit_status;
                    r_out_last   <= (CW'(r_k + ONE) == w_emit_n);
                end
                S_EMIT_HOLD: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_k <= CW'(r_k + ONE);
                        if (r_out_last) begin
                            r_in_count  <= '0;
                            r_res_count <= '0;
                            r_split     <= '0;
                            r_err       <= 1'b0;
                            r_too_long  <= 1'b0;
                            r_pfx_ok    <= 1'b1;
                            r_rc        <= '0;
                            r_pn        <= '0;
                            r_w         <= NUM_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_code  = r_out_code;
    assign o_status    = r_out_status;
    assign o_last_out  = r_out_last;

    `BID_ASSERT_IMP(a_no_out_while_collect, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `BID_ASSERT_NXT(a_last_returns_idle, i_clk, i_rst_n,
        o_out_valid && i_out_ready && o_last_out, r_state == S_COLLECT)
    `BID_ASSERT_IMP(a_res_count_bound, i_clk, i_rst_n, 1'b1, r_res_count <= MAXC)
    `BID_ASSERT_IMP(a_div_done_waiting, i_clk, i_rst_n, div_done, r_state == S_DIV_WAIT)

endmodule

@@ tb/bootstring_identifier_decoder_top_test.sv @@
module bootstring_identifier_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bid_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              bad;
        logic              last;
    } t_char_req;

    typedef struct packed {
        logic [RES_W-1:0] code;
        logic [1:0]       status;
        logic             last;
    } t_out_char;

    localparam int DEPTH = MAX_CHARS_DEF;
    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [CODE_W-1:0] i_char_code = '0;
    logic              i_bad_utf8  = 1'b0;
    logic              i_last_char = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [RES_W-1:0]  o_out_code;
    logic [1:0]        o_status;
    logic              o_last_out;

    bootstring_identifier_decoder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .i_bad_utf8  (i_bad_utf8),
        .i_last_char (i_last_char),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_code  (o_out_code),
        .o_status    (o_status),
        .o_last_out  (o_last_out)
    );

    t_char_req         pending_q[$];
    t_char_req         build_q[$];
    t_char_req         next_req;
    t_out_char         expected_q[$];
    t_out_char         got;
    logic [CODE_W-1:0] ident_q[$];
    bit                ident_bad;
    bit                ident_long;
    bit                hold_out = 1'b0;
    int                cyc;
    int                err_cnt;
    int                accepted_cnt;
    int                ident_cnt;
    int                checked_cnt;
    int                status_seen[4];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int digit_value(input logic [CODE_W-1:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "A" && c <= "Z") return int'(c) - 65 + 10;
        if (c >= "a" && c <= "z") return int'(c) - 97 + 36;
        return 64;
    endfunction

    function automatic logic [CODE_W-1:0] digit_char(input int v);
        if (v < 10) return CODE_W'(48 + v);
        if (v < 36) return CODE_W'(65 + v - 10);
        return CODE_W'(97 + v - 36);
    endfunction

    // Returns 1 when the stored identifier decodes cleanly into res.
    function automatic bit decode_ident(output logic [RES_W-1:0] res[$]);
        int          split;
        int          start;
        int          d;
        int          pos;
        logic [63:0] num;
        logic [63:0] w;
        logic [63:0] span;
        logic [31:0] run;
        split = 0;
        start = 0;
        num = 0;
        w = 1;
        run = 0;
        res = {};
        if (ident_bad) return 1'b0;
        for (int i = 4; i < ident_q.size(); i++)
            if (ident_q[i] == SPLIT_MARK) split = i - 4;
        if (split > 0) begin
            for (int i = 0; i < split; i++) res.push_back(RES_W'(ident_q[4 + i]));
            start = split + 1;
        end
        for (int i = 4 + start; i < ident_q.size(); i++) begin
            d = digit_value(ident_q[i]);
            if (d >= 62) return 1'b0;
            if (64'(d) > (U64_MAX - num) / w) return 1'b0;
            num = num + 64'(d) * w;
            if (d < 31) begin
                span = 64'(res.size()) + 64'd1;
                pos = int'(num % span);
                run = run + 32'(num / span);
                if (res.size() >= DEPTH) return 1'b0;
                res.insert(pos, run);
                num = 0;
                w = 1;
            end else begin
                if (w > U64_MAX / 64'd31) return 1'b0;
                w = w * 64'd31;
            end
        end
        return w == 64'd1;
    endfunction

    task automatic echo_ident(input logic [1:0] st);
        for (int k = 0; k < ident_q.size(); k++)
            expected_q.push_back('{RES_W'(ident_q[k]), st, k == ident_q.size() - 1});
    endtask

    task automatic take_char(input logic [CODE_W-1:0] c, input logic b, input logic l);
        logic [RES_W-1:0] res[$];
        if (ident_q.size() < DEPTH) begin
            ident_q.push_back(c);
            if (b) ident_bad = 1'b1;
        end else begin
            ident_long = 1'b1;
        end
        if (l) begin
            ident_cnt++;
            if (ident_long) begin
                echo_ident(ST_TOO_LONG);
                status_seen[ST_TOO_LONG]++;
            end else if (ident_q.size() < 4 || ident_q[0] != "t" || ident_q[1] != "n" ||
                         ident_q[2] != SPLIT_MARK || ident_q[3] != SPLIT_MARK) begin
                echo_ident(ST_NO_PFX);
                status_seen[ST_NO_PFX]++;
            end else if (!decode_ident(res)) begin
                echo_ident(ST_DEC_ERR);
                status_seen[ST_DEC_ERR]++;
            end else begin
                for (int k = 0; k < res.size(); k++)
                    expected_q.push_back('{res[k], ST_DECODED, k == res.size() - 1});
                status_seen[ST_DECODED]++;
            end
            ident_q = {};
            ident_bad = 1'b0;
            ident_long = 1'b0;
        end
    endtask

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic put(input logic [CODE_W-1:0] c, input bit b = 1'b0);
        build_q.push_back('{c, b, 1'b0});
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put(CODE_W'(s[i]));
    endtask

    // One variable-length number: continuation digits, then a terminating one.
    task automatic put_num(input int ndig);
        for (int k = 0; k < ndig - 1; k++) put(digit_char($urandom_range(31, 61)));
        put(digit_char($urandom_range(0, 30)));
    endtask

    task automatic close_ident();
        if (build_q.size() == 0) return;
        build_q[build_q.size() - 1].last = 1'b1;
        foreach (build_q[i]) pending_q.push_back(build_q[i]);
        build_q = {};
    endtask

    task automatic random_ident();
        int nlit;
        int nnum;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            // Noise with arbitrary code points and bad flags.
            repeat ($urandom_range(1, 8))
                put(CODE_W'($urandom_range(0, 21'h10FFFF)), $urandom_range(0, 9) == 0);
        end else if (kind < 16) begin
            put_str("tn__");
            repeat ($urandom_range(55, 70)) put(digit_char($urandom_range(0, 61)));
        end else begin
            put_str("tn__");
            nlit = $urandom_range(0, 5);
            for (int i = 0; i < nlit; i++) begin
                if ($urandom_range(0, 1)) put(CODE_W'($urandom_range(0, 21'h10FFFF)));
                else put(CODE_W'($urandom_range(33, 126)));
                if (build_q[build_q.size() - 1].code == SPLIT_MARK)
                    build_q[build_q.size() - 1].code = "x";
            end
            if (nlit > 0 || $urandom_range(0, 9) == 0) put(SPLIT_MARK);
            nnum = $urandom_range(1, 6);
            for (int i = 0; i < nnum; i++)
                put_num($urandom_range(0, 3) == 0 ? $urandom_range(2, 5) : $urandom_range(1, 2));
            if (kind < 24) begin
                build_q[$urandom_range(4, build_q.size() - 1)].bad = 1'b1;
            end else if (kind < 30) begin
                put(digit_char($urandom_range(31, 61)));
            end else if (kind < 34) begin
                build_q[$urandom_range(4, build_q.size() - 1)].code =
                    CODE_W'($urandom_range(123, 21'h10FFFF));
            end
        end
        close_ident();
    endtask

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                take_char(i_char_code, i_bad_utf8, i_last_char);
                accepted_cnt++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_q.size() > 0 &&
                    ((cyc > 2000 && cyc < 4500) || $urandom_range(0, 99) >= 15)) begin
                    next_req = pending_q.pop_front();
                    i_char_code <= next_req.code;
                    i_bad_utf8  <= next_req.bad;
                    i_last_char <= next_req.last;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_out_code, o_status, o_last_out};
                if (expected_q.size() == 0) begin
                    report($sformatf("result %h with nothing pending", o_out_code));
                end else begin
                    checked_cnt++;
                    if (got.code !== expected_q[0].code)
                        report($sformatf("out_code %h, want %h", got.code, expected_q[0].code));
                    if (got.status !== expected_q[0].status)
                        report($sformatf("status %0d, want %0d", got.status,
                                         expected_q[0].status));
                    if (got.last !== expected_q[0].last)
                        report($sformatf("last_out %b, want %b", got.last, expected_q[0].last));
                    void'(expected_q.pop_front());
                end
            end
            i_out_ready <= !hold_out &&
                           ((cyc > 2000 && cyc < 4500) || $urandom_range(0, 99) >= 15);
        end
    end

    // Stall the receiver for a long stretch so the decoder backs up its input.
    initial begin
        wait (accepted_cnt >= 150);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    initial begin
        #20ms;
        $display("[bootstring_identifier_decoder_top] ERROR");
        $finish;
    end

    initial begin
        // Directed identifiers.
        put_str("tn__");                    close_ident();
        put_str("tn");                      close_ident();
        put(21'h10FFFF); put(21'h0);        close_ident();
        put_str("tn__ab_A");                close_ident();
        put_str("tn__"); put("a", 1'b1);    close_ident();
        put_str("tn__Z");                   close_ident();
        put_str("tn___");                   close_ident();
        put_str("tn__"); put(21'h10FFFF); put_str("_0"); close_ident();
        put_str("tn__zzzzzzzzzzzzzz0");     close_ident();
        put_str("tn__a!");                  close_ident();
        put_str("tN__a");                   close_ident();
        put_str("tn__");
        repeat (62) put("a");
        close_ident();
        repeat (70) put("q");
        close_ident();
        while (pending_q.size() < 410) random_ident();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() > 0 || i_in_valid) @(posedge i_clk);
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (expected_q.size() != 0)
            report($sformatf("%0d results never arrived", expected_q.size()));
        $display("ran %0d identifiers (%0d code points), checked %0d output code points",
                 ident_cnt, accepted_cnt, checked_cnt);
        $display("decoded %0d, no prefix %0d, decode error %0d, too long %0d",
                 status_seen[ST_DECODED], status_seen[ST_NO_PFX],
                 status_seen[ST_DEC_ERR], status_seen[ST_TOO_LONG]);
        if (err_cnt == 0) begin
            $display("[bootstring_identifier_decoder_top] OK");
        end else begin
            $display("[bootstring_identifier_decoder_top] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/bid_pkg.sv
hdl/bid_ram.sv
hdl/bid_div.sv
hdl/bootstring_identifier_decoder_top.sv
tb/bootstring_identifier_decoder_top_test.sv
